// ===== design/life_automaton_column_step_assert.svh =====
// Assertion macros for the life automaton column step back end
`ifndef LIFE_AUTOMATON_COLUMN_STEP_ASSERT_SVH
`define LIFE_AUTOMATON_COLUMN_STEP_ASSERT_SVH

// Same-cycle implication, checked on clk_i, off during reset
`define LACS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk_i, off during reset
`define LACS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/lacs_pkg.sv =====
// Types, constants and cell rule functions for the life automaton column step
package lacs_pkg;

  localparam int MaxHeight = 64;
  localparam int ColWidth  = 64;

  typedef logic [ColWidth-1:0] col_t;

  typedef struct packed {
    col_t column_cells;
    logic last_column;
  } in_item_t;

  typedef struct packed {
    col_t next_cells;
    logic grid_done;
  } out_item_t;

  // What the back end does with a queued column
  typedef enum logic [1:0] {
    OP_HOLD,    // first column of a grid: store only
    OP_SINGLE,  // first and last column: one result
    OP_STEP,    // interior column: emit the middle column
    OP_LAST     // last column: emit middle and last column
  } op_e;

  typedef struct packed {
    op_e  op;
    col_t cells;
  } queue_entry_t;

  // Mask of rows below the (saturated) height
  function automatic col_t row_mask(logic [6:0] height);
    logic [6:0] h_sat;
    col_t       m;
    h_sat = (height > 7'(MaxHeight)) ? 7'(MaxHeight) : height;
    for (int k = 0; k < ColWidth; k++) begin
      m[k] = (7'(k) < h_sat);
    end
    return m;
  endfunction

  // One generation of B3/S23 for the middle column; the cell itself is not counted
  function automatic col_t next_gen(col_t lf, col_t md, col_t rt);
    logic [ColWidth+1:0] lf_x;
    logic [ColWidth+1:0] md_x;
    logic [ColWidth+1:0] rt_x;
    logic [3:0]          n;
    col_t                res;
    lf_x = {1'b0, lf, 1'b0};
    md_x = {1'b0, md, 1'b0};
    rt_x = {1'b0, rt, 1'b0};
    for (int k = 0; k < ColWidth; k++) begin
      n = {3'b000, lf_x[k]} + {3'b000, lf_x[k+1]} + {3'b000, lf_x[k+2]}
        + {3'b000, rt_x[k]} + {3'b000, rt_x[k+1]} + {3'b000, rt_x[k+2]}
        + {3'b000, md_x[k]} + {3'b000, md_x[k+2]};
      res[k] = (n == 4'd3) || ((n == 4'd2) && md[k]);
    end
    return res;
  endfunction

endpackage

// ===== design/lacs_front.sv =====
// Front end: accepts columns and tags each with its place in the grid
module lacs_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  lacs_pkg::in_item_t     in_item_i,
  input  logic                   q_full_i,
  output logic                   q_push_o,
  output lacs_pkg::queue_entry_t q_entry_o
);
  import lacs_pkg::*;

  logic have_middle_q, have_middle_d;

  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && in_ready_o;

  always_comb begin
    q_entry_o.cells = in_item_i.column_cells;
    if (!have_middle_q) begin
      q_entry_o.op = in_item_i.last_column ? OP_SINGLE : OP_HOLD;
    end else begin
      q_entry_o.op = in_item_i.last_column ? OP_LAST : OP_STEP;
    end
  end

  // a last column closes the grid
  assign have_middle_d = q_push_o ? !in_item_i.last_column : have_middle_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_middle_q <= 1'b0;
    end else begin
      have_middle_q <= have_middle_d;
    end
  end

endmodule

// ===== design/lacs_queue.sv =====
// Two-entry queue between the front and back ends
module lacs_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  lacs_pkg::queue_entry_t entry_i,
  output logic                   full_o,
  input  logic                   pop_i,
  output logic                   valid_o,
  output lacs_pkg::queue_entry_t entry_o
);
  import lacs_pkg::*;

  queue_entry_t slot_q [2];
  logic         wr_ptr_q, wr_ptr_d;
  logic         rd_ptr_q, rd_ptr_d;
  logic [1:0]   count_q, count_d;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign entry_o = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// ===== design/lacs_back.sv =====
// Back end: holds the column window, computes next generations, drives results
`include "life_automaton_column_step_assert.svh"

module lacs_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  lacs_pkg::col_t         mask_i,
  input  logic                   q_valid_i,
  input  lacs_pkg::queue_entry_t q_entry_i,
  output logic                   q_pop_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output lacs_pkg::out_item_t    out_item_o
);
  import lacs_pkg::*;

  col_t      left_q, left_d;
  col_t      mid_q, mid_d;
  col_t      pend_q, pend_d;
  logic      pend_valid_q, pend_valid_d;
  out_item_t out_q, out_d;
  logic      out_valid_q, out_valid_d;

  logic      can_load;
  logic      is_hold;
  logic      is_single;
  col_t      cur_m, left_m, mid_m;
  col_t      gen_a, gen_b;

  assign can_load  = !out_valid_q || out_ready_i;
  assign is_hold   = (q_entry_i.op == OP_HOLD);
  assign is_single = (q_entry_i.op == OP_SINGLE);
  // a held column needs no output slot; it drains under stall if !pend_valid_q
  assign q_pop_o   = q_valid_i && !pend_valid_q && (is_hold || can_load);

  assign cur_m  = q_entry_i.cells & mask_i;
  assign left_m = left_q & mask_i;
  assign mid_m  = mid_q & mask_i;

  assign gen_a = next_gen(is_single ? '0 : left_m, is_single ? cur_m : mid_m,
                          is_single ? '0 : cur_m) & mask_i;
  assign gen_b = next_gen(mid_m, cur_m, '0) & mask_i;

  always_comb begin
    left_d       = left_q;
    mid_d        = mid_q;
    pend_d       = pend_q;
    pend_valid_d = pend_valid_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q;

    if (can_load) begin
      out_valid_d = pend_valid_q || (q_pop_o && !is_hold);
    end

    if (can_load && pend_valid_q) begin
      out_d.next_cells = pend_q;
      out_d.grid_done  = 1'b1;
      pend_valid_d     = 1'b0;
    end

    if (q_pop_o) begin
      case (q_entry_i.op)
        OP_HOLD: begin
          left_d = '0;
          mid_d  = cur_m;
        end
        OP_SINGLE: begin
          out_d.next_cells = gen_a;
          out_d.grid_done  = 1'b1;
          left_d           = '0;
          mid_d            = '0;
        end
        OP_STEP: begin
          out_d.next_cells = gen_a;
          out_d.grid_done  = 1'b0;
          left_d           = mid_q;
          mid_d            = cur_m;
        end
        OP_LAST: begin
          out_d.next_cells = gen_a;
          out_d.grid_done  = 1'b0;
          pend_d           = gen_b;
          pend_valid_d     = 1'b1;
          left_d           = '0;
          mid_d            = '0;
        end
        default: begin
          left_d = left_q;
          mid_d  = mid_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    left_q <= left_d;
    mid_q  <= mid_d;
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `LACS_ASSERT_NOW(a_pend_behind_out, pend_valid_q, out_valid_q, "pending item without shown item")
  `LACS_ASSERT_NOW(a_pend_after_open, pend_valid_q, !out_q.grid_done, "grid closed before last item")
  `LACS_ASSERT_NEXT(a_last_sets_pend, q_pop_o && q_entry_i.op == OP_LAST, pend_valid_q, "last column lost")

endmodule

// ===== design/life_automaton_column_step.sv =====
// Life automaton column step: one B3/S23 generation, one grid column per item
//
// Input channel (in_valid_i/in_ready_o, in_item_i) takes grid columns left to
// right; bit k of column_cells is row k, last_column marks the grid's end.
// Output channel (out_valid_o/out_ready_i, out_item_o) gives next-generation
// columns; grid_done is set on the result for the last column.
// The first column of a grid yields no item unless it is also the last; each
// later column yields the result of the column before it; the last column
// yields two items. Column x's result is registered at the output as column
// x+1 leaves the queue. Throughput: one column per cycle while the receiver
// takes results, set by the back end's single output register, which a last
// column holds for a second result before the next is taken. A two-entry queue
// parts the front and back ends, so input keeps flowing while an item waits at
// the output; a stalled receiver fills the queue and then drops in_ready_o.
// cfg_we_i/cfg_data_i write column_height (reset 64); rows at or above it are
// dead. The user must write it only while the block is idle; the block does
// not enforce this. Reset empties the queue and output and starts a new grid.
module life_automaton_column_step (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [6:0]          cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  lacs_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output lacs_pkg::out_item_t out_item_o
);
  import lacs_pkg::*;

  col_t         mask_q, mask_d;
  logic         q_push, q_full, q_pop, q_valid;
  queue_entry_t q_in, q_out;

  assign mask_d = cfg_we_i ? row_mask(cfg_data_i) : mask_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= row_mask(7'(MaxHeight));
    end else begin
      mask_q <= mask_d;
    end
  end

  lacs_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_entry_o  (q_in)
  );

  lacs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .entry_o (q_out)
  );

  lacs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mask_i      (mask_q),
    .q_valid_i   (q_valid),
    .q_entry_i   (q_out),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

// ===== test/tb_life_automaton_column_step.sv =====
// Testbench for life_automaton_column_step: random and directed grids against a B3/S23 scoreboard
module tb_life_automaton_column_step;
  import lacs_pkg::*;

  localparam int NumPhases      = 9;
  localparam int ColumnsPerStep = 66;
  localparam int StallLimit     = 4000;
  localparam int SettleCycles   = 4;

  class life_scoreboard;
    logic [6:0] height;
    col_t       west_col;
    col_t       held_col;
    bit         holding;
    out_item_t  gen_due_q[$];
    int         errors;
    int         columns_in;
    int         columns_out;
    int         grids;

    function new();
      height     = 7'(MaxHeight);
      west_col   = '0;
      held_col   = '0;
      holding    = 1'b0;
      errors     = 0;
      columns_in = 0;
      columns_out = 0;
      grids      = 0;
    endfunction

    function col_t live_rows();
      int   h;
      col_t m;
      h = (height > 7'(MaxHeight)) ? MaxHeight : int'(height);
      for (int k = 0; k < ColWidth; k++) begin
        m[k] = (k < h);
      end
      return m;
    endfunction

    // Count the eight neighbors of each cell in the center column; rows off the edge are dead
    function col_t evolve_column(col_t west, col_t center, col_t east);
      col_t res;
      int   n;
      int   r;
      for (int k = 0; k < ColWidth; k++) begin
        n = 0;
        for (int d = -1; d <= 1; d++) begin
          r = k + d;
          if (r >= 0 && r < ColWidth) begin
            n += int'(west[r]) + int'(east[r]);
            if (d != 0) n += int'(center[r]);
          end
        end
        res[k] = (n == 3) || (n == 2 && center[k]);
      end
      return res & live_rows();
    endfunction

    function void push_gen(col_t cells, logic done);
      out_item_t e;
      e.next_cells = cells;
      e.grid_done  = done;
      gen_due_q.push_back(e);
    endfunction

    function void note_column(in_item_t it);
      col_t m;
      col_t cur;
      m   = live_rows();
      cur = it.column_cells & m;
      columns_in++;
      if (!holding) begin
        if (it.last_column) begin
          push_gen(evolve_column('0, cur, '0), 1'b1);
          grids++;
        end else begin
          west_col = '0;
          held_col = cur;
          holding  = 1'b1;
        end
        return;
      end
      push_gen(evolve_column(west_col & m, held_col & m, cur), 1'b0);
      if (it.last_column) begin
        push_gen(evolve_column(held_col & m, cur, '0), 1'b1);
        west_col = '0;
        held_col = '0;
        holding  = 1'b0;
        grids++;
      end else begin
        west_col = held_col;
        held_col = cur;
      end
    endfunction

    function void check_column(out_item_t got);
      out_item_t e;
      columns_out++;
      if (gen_due_q.size() == 0) begin
        $error("unexpected result: next_cells %h grid_done %b", got.next_cells, got.grid_done);
        errors++;
        return;
      end
      e = gen_due_q.pop_front();
      if (got.next_cells !== e.next_cells) begin
        $error("next_cells: expected %h, actual %h", e.next_cells, got.next_cells);
        errors++;
      end
      if (got.grid_done !== e.grid_done) begin
        $error("grid_done: expected %b, actual %b", e.grid_done, got.grid_done);
        errors++;
      end
    endfunction

    function int pending();
      return gen_due_q.size();
    endfunction
  endclass

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       cfg_we_i    = 1'b0;
  logic [6:0] cfg_data_i  = '0;
  logic       in_valid_i  = 1'b0;
  logic       in_ready_o;
  in_item_t   in_item_i   = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  out_item_t  out_item_o;

  life_automaton_column_step dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

  life_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_count   = 0;
  int phase_columns = 0;
  int heights_used  = 1;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Track accepted items on both channels and bail out if the block goes quiet
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_column(in_item_i);
      if (out_valid_o && out_ready_i) sb.check_column(out_item_o);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        stall_count <= 0;
      end else if (stall_count >= StallLimit) begin
        $display("watchdog: no item accepted for %0d cycles", StallLimit);
        $display("end of test: mismatches");
        $finish;
      end else begin
        stall_count <= stall_count + 1;
      end
    end
  end

  task automatic send_column(input col_t cells, input logic last);
    in_item_t it;
    it.column_cells = cells;
    it.last_column  = last;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    phase_columns++;
  endtask

  // Drop valid and hold until every result is back and the pipeline has settled
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_height(input logic [6:0] h);
    cfg_data_i <= h;
    cfg_we_i   <= 1'b1;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    sb.height = h;
  endtask

  function automatic col_t random_cells();
    col_t a;
    col_t b;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    case ($urandom_range(7))
      0, 1, 2: return a;
      3, 4:    return a & b;
      5:       return a | b;
      6:       return a & b & {$urandom, $urandom};
      default: return ($urandom_range(1) != 0) ? '1 : '0;
    endcase
  endfunction

  task automatic send_random_grid();
    int len;
    len = ($urandom_range(5) == 0) ? 1 : $urandom_range(2, 10);
    for (int c = 0; c < len; c++) begin
      send_column(random_cells(), c == len - 1);
    end
  endtask

  task automatic run_directed();
    // single-column grids
    send_column('1, 1'b1);
    send_column('0, 1'b1);
    // two columns, both full
    send_column('1, 1'b0);
    send_column('1, 1'b1);
    // blinker across three columns
    send_column(64'h20, 1'b0);
    send_column(64'h20, 1'b0);
    send_column(64'h20, 1'b1);
    // glider with an empty trailing column
    send_column(64'h4, 1'b0);
    send_column(64'h5, 1'b0);
    send_column(64'h6, 1'b0);
    send_column(64'h0, 1'b1);
    // top and bottom rows, alternating rows
    send_column(64'h8000_0000_0000_0001, 1'b0);
    send_column(64'hC000_0000_0000_0003, 1'b0);
    send_column(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
    send_column(64'h5555_5555_5555_5555, 1'b0);
    send_column(64'hFFFF_FFFF_0000_0000, 1'b1);
  endtask

  initial begin
    logic [6:0] heights [NumPhases];
    heights = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd65, 7'd2, 7'd3, 7'd63, 7'd64};
    heights[6] = 7'($urandom_range(3, 62));
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int p = 0; p < NumPhases; p++) begin
      case (p / 3)
        0: begin send_idle_pct = 16; recv_idle_pct = 51; end
        1: begin send_idle_pct = 51; recv_idle_pct = 16; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      if (p != 0) begin
        wait_idle();
        set_height(heights[p]);
        heights_used++;
      end
      phase_columns = 0;
      if (p == 0) run_directed();
      while (phase_columns < ColumnsPerStep) send_random_grid();
    end
    wait_idle();
    repeat (8) @(posedge clk_i);
    if (sb.pending() != 0) begin
      $error("%0d result columns never arrived", sb.pending());
      sb.errors++;
    end
    $display("ran %0d columns in %0d grids under %0d column heights",
             sb.columns_in, sb.grids, heights_used);
    $display("checked %0d result columns with sender and receiver stalls", sb.columns_out);
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
